@@ sv/slhe_pkg.sv @@
// slhe_pkg: shared types and constants of the salted lane hash engine
// lane array type, salted start table, bank operation codes, sequencer states
// no dependencies
package slhe_pkg;

  localparam int unsigned NUM_LANES = 8;
  localparam int unsigned SALT_LEN  = 12;
  localparam int unsigned HEX_CHARS = 64;
  localparam int unsigned LANE_W    = 32;
  localparam int unsigned PTR_W     = 3;
  localparam int unsigned CHR_W     = 6;

  localparam logic [LANE_W-1:0] ABSORB_MULT  = 32'd33;
  localparam logic [LANE_W-1:0] DIFFUSE_MULT = 32'h9e3779b9;

  typedef logic [LANE_W-1:0] lane_arr_t [NUM_LANES];
  typedef logic [7:0]        salt_arr_t [SALT_LEN];

  localparam lane_arr_t LANE_SEED = '{
    32'h6b8b4567, 32'h327b23c6, 32'h643c9869, 32'h66334873,
    32'h74b0dc51, 32'h19495cff, 32'h2ae8944a, 32'h625558ec
  };

  localparam salt_arr_t SALT = '{
    8'h70, 8'h69, 8'h63, 8'h6f, 8'h63, 8'h61,
    8'h6c, 8'h63, 8'h2d, 8'h76, 8'h31, 8'h3a
  };

  // salt absorbed into the seed at elaboration
  function automatic lane_arr_t salted_start_f();
    lane_arr_t l;
    l = LANE_SEED;
    for (int s = 0; s < int'(SALT_LEN); s++) begin
      for (int k = 0; k < int'(NUM_LANES); k++) begin
        l[k] = l[k] * ABSORB_MULT + {24'b0, SALT[s]} + LANE_W'(k);
      end
    end
    return l;
  endfunction

  localparam lane_arr_t SALTED_START = salted_start_f();

  typedef enum logic [2:0] {
    BANK_HOLD,
    BANK_LOAD,
    BANK_ROTATE,
    BANK_ABSORB,
    BANK_DIFFUSE,
    BANK_SHIFT_NIB
  } bank_op_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ABS_MUL,
    S_ABS_WB,
    S_ALIGN_PRE,
    S_DIF_MUL,
    S_DIF_WB,
    S_ALIGN_POST,
    S_EMIT
  } seq_state_e;

endpackage

@@ sv/slhe_mul.sv @@
// slhe_mul: shared 32x32 multiplier, low word of the product registered
// depends on slhe_pkg
module slhe_mul
  import slhe_pkg::*;
(
  input  logic              clk_i,
  input  logic [LANE_W-1:0] op_a_i,
  input  logic [LANE_W-1:0] op_b_i,
  output logic [LANE_W-1:0] prod_o
);

  logic [LANE_W-1:0] prod_q;
  logic [LANE_W-1:0] prod_d;

  assign prod_d = op_a_i * op_b_i;

  always_ff @(posedge clk_i) begin
    prod_q <= prod_d;
  end

  assign prod_o = prod_q;

endmodule

@@ sv/slhe_lane_bank.sv @@
// slhe_lane_bank: eight lanes kept as a rotating ring, head lane at position 0
// depends on slhe_pkg
module slhe_lane_bank
  import slhe_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  bank_op_e          op_i,
  input  logic [7:0]        byte_i,
  input  logic [LANE_W-1:0] prod_i,
  output logic [LANE_W-1:0] head_o,
  output logic [LANE_W-1:0] tap3_o,
  output logic [3:0]        nibble_o
);

  lane_arr_t lane_q;
  lane_arr_t lane_d;
  logic [LANE_W-1:0] mixed;
  logic [LANE_W-1:0] tail_new;

  assign mixed = lane_q[0] ^ prod_i;

  always_comb begin
    lane_d   = lane_q;
    tail_new = lane_q[0];
    case (op_i)
      BANK_ABSORB:  tail_new = prod_i ^ {24'b0, byte_i};
      BANK_DIFFUSE: tail_new = {mixed[LANE_W-8:0], mixed[LANE_W-1:LANE_W-7]};
      default:      tail_new = lane_q[0];
    endcase
    case (op_i)
      BANK_LOAD: begin
        lane_d = SALTED_START;
      end
      BANK_ROTATE, BANK_ABSORB, BANK_DIFFUSE: begin
        for (int i = 0; i < int'(NUM_LANES) - 1; i++) begin
          lane_d[i] = lane_q[i+1];
        end
        lane_d[NUM_LANES-1] = tail_new;
      end
      BANK_SHIFT_NIB: begin
        // ring read as one wide word, head most significant
        for (int i = 0; i < int'(NUM_LANES) - 1; i++) begin
          lane_d[i] = {lane_q[i][LANE_W-5:0], lane_q[i+1][LANE_W-1:LANE_W-4]};
        end
        lane_d[NUM_LANES-1] = {lane_q[NUM_LANES-1][LANE_W-5:0], 4'b0};
      end
      default: begin
        lane_d = lane_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lane_q <= SALTED_START;
    end else begin
      lane_q <= lane_d;
    end
  end

  assign head_o   = lane_q[0];
  assign tap3_o   = lane_q[3];
  assign nibble_o = lane_q[0][LANE_W-1:LANE_W-4];

endmodule

@@ sv/salted_lane_hash_engine_core.sv @@
// salted_lane_hash_engine_core: top level, sequencer around the shared multiplier
// depends on slhe_pkg, slhe_mul, slhe_lane_bank
//
// Each word on start carries at most one password byte. A word with a byte keeps
// busy high for one pass through the shared multiplier and one write back, and the
// next byte can be taken only once busy is low again; a word with no byte and no end
// mark leaves busy low, and the next word can follow at once. On the end mark the
// block realigns the lane ring (up to 7 one-place rotations), runs DIFFUSION_ROUNDS
// rounds through the same multiplier, each a multiply and a write back, realigns
// again and then sends the 64 hex characters of the digest, one per cycle on
// result_valid_o, the last one flagged by last_char_o. The receiver cannot stall:
// every character is valid for exactly one cycle. busy stays high from the cycle
// after acceptance until the last character has gone, and the salted start is
// reloaded at the edge that ends the last character. There is no clearing pass
// after reset.
module salted_lane_hash_engine_core
  import slhe_pkg::*;
#(
  parameter int unsigned DIFFUSION_ROUNDS = 64
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [7:0] pw_byte_i,
  input  logic       byte_present_i,
  input  logic       end_of_password_i,
  output logic       result_valid_o,
  output logic [6:0] hex_char_o,
  output logic       last_char_o
);

  localparam int unsigned RND_W = (DIFFUSION_ROUNDS > 1) ? $clog2(DIFFUSION_ROUNDS) : 1;
  localparam logic [RND_W-1:0] RND_LAST = RND_W'(DIFFUSION_ROUNDS - 1);
  localparam logic [CHR_W-1:0] CHR_LAST = CHR_W'(HEX_CHARS - 1);

  seq_state_e state_q, state_d;
  logic [PTR_W-1:0] off_q, off_d;   // logical lane sitting at ring position 0
  logic [RND_W-1:0] rnd_q, rnd_d;
  logic [CHR_W-1:0] chr_q, chr_d;
  logic [7:0]       byte_q;
  logic             last_q;
  logic             accept;

  bank_op_e          bank_op;
  logic [LANE_W-1:0] head;
  logic [LANE_W-1:0] tap3;
  logic [3:0]        nibble;
  logic [LANE_W-1:0] mul_a;
  logic [LANE_W-1:0] mul_b;
  logic [LANE_W-1:0] prod;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;

  // one multiplier: x33 on the head lane when absorbing, golden ratio on lane+3 otherwise
  assign mul_a = (state_q == S_ABS_MUL) ? head : tap3;
  assign mul_b = (state_q == S_ABS_MUL) ? ABSORB_MULT : DIFFUSE_MULT;

  slhe_mul u_mul (
    .clk_i  (clk_i),
    .op_a_i (mul_a),
    .op_b_i (mul_b),
    .prod_o (prod)
  );

  slhe_lane_bank u_bank (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .op_i     (bank_op),
    .byte_i   (byte_q),
    .prod_i   (prod),
    .head_o   (head),
    .tap3_o   (tap3),
    .nibble_o (nibble)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (byte_present_i) begin
            state_d = S_ABS_MUL;
          end else if (end_of_password_i) begin
            state_d = S_ALIGN_PRE;
          end
        end
      end
      S_ABS_MUL:    state_d = S_ABS_WB;
      S_ABS_WB:     state_d = last_q ? S_ALIGN_PRE : S_IDLE;
      S_ALIGN_PRE: begin
        if (off_q == '0) begin
          state_d = S_DIF_MUL;
        end
      end
      S_DIF_MUL:    state_d = S_DIF_WB;
      S_DIF_WB: begin
        if (rnd_q == RND_LAST) begin
          state_d = S_ALIGN_POST;
        end else begin
          state_d = S_DIF_MUL;
        end
      end
      S_ALIGN_POST: begin
        if (off_q == '0) begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (chr_q == CHR_LAST) begin
          state_d = S_IDLE;
        end
      end
      default:      state_d = S_IDLE;
    endcase
  end

  // datapath control and counters
  always_comb begin
    bank_op = BANK_HOLD;
    off_d   = off_q;
    rnd_d   = rnd_q;
    chr_d   = chr_q;
    case (state_q)
      S_ABS_WB: begin
        bank_op = BANK_ABSORB;
        off_d   = off_q + 1'b1;
      end
      S_ALIGN_PRE: begin
        rnd_d = '0;
        if (off_q != '0) begin
          bank_op = BANK_ROTATE;
          off_d   = off_q + 1'b1;
        end
      end
      S_DIF_WB: begin
        bank_op = BANK_DIFFUSE;
        off_d   = off_q + 1'b1;
        rnd_d   = rnd_q + 1'b1;
      end
      S_ALIGN_POST: begin
        chr_d = '0;
        if (off_q != '0) begin
          bank_op = BANK_ROTATE;
          off_d   = off_q + 1'b1;
        end
      end
      S_EMIT: begin
        chr_d = chr_q + 1'b1;
        if (chr_q == CHR_LAST) begin
          // digest gone, back to the salted start
          bank_op = BANK_LOAD;
          off_d   = '0;
        end else begin
          bank_op = BANK_SHIFT_NIB;
        end
      end
      default: begin
        bank_op = BANK_HOLD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      off_q   <= '0;
      rnd_q   <= '0;
      chr_q   <= '0;
    end else begin
      state_q <= state_d;
      off_q   <= off_d;
      rnd_q   <= rnd_d;
      chr_q   <= chr_d;
    end
  end

  // input word capture
  always_ff @(posedge clk_i) begin
    if (accept) begin
      byte_q <= pw_byte_i;
      last_q <= end_of_password_i;
    end
  end

  // nibble to lowercase ascii
  assign result_valid_o = (state_q == S_EMIT);
  assign hex_char_o     = (nibble < 4'd10) ? (7'h30 + {3'b0, nibble})
                                           : (7'h57 + {3'b0, nibble});
  assign last_char_o    = result_valid_o && (chr_q == CHR_LAST);

  // assertions
  a_valid_only_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> busy)
    else $error("result strobe while idle");

  a_last_ends_burst : assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_char_o |=> !result_valid_o && !busy)
    else $error("characters continue after the last one");

  a_empty_word_no_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !byte_present_i && !end_of_password_i) |=> !busy)
    else $error("empty word left the engine busy");

  a_emit_aligned : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT) |-> (off_q == '0))
    else $error("digest sent from a misaligned lane ring");

endmodule
